### rtl/tsprt_pkg.sv
// ----------------------------------------------------------------------------
// tsprt_pkg
// Shared types and constants of the transport stream PCR reference tracker.
// ----------------------------------------------------------------------------
package tsprt_pkg;

  // Candidate table
  localparam int CandSlots = 8;
  localparam int CandIdxW  = (CandSlots > 1) ? $clog2(CandSlots) : 1;
  localparam int CandCntW  = $clog2(CandSlots + 1);

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_IDLE_GAP      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_NORMAL_WINDOW = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_SEEK_LIMIT    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_PROMOTE_COUNT = CfgIdxW'(3);

  localparam logic [15:0] IDLE_GAP_RST      = 16'd2000;
  localparam logic [19:0] NORMAL_WINDOW_RST = 20'd45000;
  localparam logic [25:0] SEEK_LIMIT_RST    = 26'd40500000;
  localparam logic [2:0]  PROMOTE_COUNT_RST = 3'd5;

  // Header bit positions
  localparam int B1_ERR     = 7;
  localparam int B1_PUSI    = 6;
  localparam int B3_ADAPT   = 5;
  localparam int B3_PAYLOAD = 4;
  localparam int AF_PCR     = 4;

  localparam logic [12:0] TT_PID       = 13'h014;
  localparam logic [7:0]  PCR_MIN_ALEN = 8'd5;
  localparam logic [2:0]  HITS_MAX     = 3'd7;
  localparam logic [31:0] PCR_MAX      = 32'hFFFF_FFFF;
  localparam logic [33:0] PCR_WRAP_ADD = 34'h1_0000_0000;

  typedef struct packed {
    logic        seen;
    logic        tt;
    logic [12:0] pid;
    logic [31:0] pcr;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [15:0] idle_gap_ms;
    logic [19:0] normal_window;
    logic [25:0] seek_limit;
    logic [2:0]  promote_count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/ts_pcr_reference_tracker_core.sv
// ----------------------------------------------------------------------------
// ts_pcr_reference_tracker_core
// Accepted header beats enter a two-beat queue, which lets the front accept
// while the back is busy. The four-step back sequencer (idle, table, diff,
// done) takes one item at a time and registers its result, stalling in done.
// Reset: synchronous active low; clears the reference, the candidate count,
// the last PCR and time stamp, and loads the register defaults.
// ----------------------------------------------------------------------------
module ts_pcr_reference_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_hdr_byte1,
  input  logic [7:0]                      in_hdr_byte2,
  input  logic [7:0]                      in_hdr_byte3,
  input  logic [7:0]                      in_adapt_length,
  input  logic [7:0]                      in_adapt_flags,
  input  logic [31:0]                     in_pcr_top,
  input  logic [31:0]                     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_pcr_seen,
  output logic                            out_time_table_packet,
  output logic                            out_ref_valid,
  output logic [12:0]                     out_ref_pid,
  output logic                            out_is_reference,
  output logic                            out_stream_reset,
  output logic                            out_seek_detected,
  output logic signed [26:0]              out_pcr_jump,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsprt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tsprt_pkg::CfgDataW-1:0]  cfg_data
);
  import tsprt_pkg::*;

  cfg_t     cfg_r;
  q_stat_t  q_stat;
  logic     q_push;
  item_t    q_push_item;
  logic     q_pop;
  logic     q_valid;
  item_t    q_pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_gap_ms   <= IDLE_GAP_RST;
      cfg_r.normal_window <= NORMAL_WINDOW_RST;
      cfg_r.seek_limit    <= SEEK_LIMIT_RST;
      cfg_r.promote_count <= PROMOTE_COUNT_RST;
    end else if (cfg_valid) begin
      // Writes to an index outside the register list are dropped.
      unique case (cfg_index)
        REG_IDLE_GAP:      cfg_r.idle_gap_ms   <= cfg_data[15:0];
        REG_NORMAL_WINDOW: cfg_r.normal_window <= cfg_data[19:0];
        REG_SEEK_LIMIT:    cfg_r.seek_limit    <= cfg_data[25:0];
        REG_PROMOTE_COUNT: cfg_r.promote_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  tsprt_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hdr_byte1    (in_hdr_byte1),
    .in_hdr_byte2    (in_hdr_byte2),
    .in_hdr_byte3    (in_hdr_byte3),
    .in_adapt_length (in_adapt_length),
    .in_adapt_flags  (in_adapt_flags),
    .in_pcr_top      (in_pcr_top),
    .in_now_ms       (in_now_ms),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (q_push_item)
  );

  tsprt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item),
    .stat      (q_stat)
  );

  tsprt_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (q_valid),
    .q_item                (q_pop_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_pcr_seen          (out_pcr_seen),
    .out_time_table_packet (out_time_table_packet),
    .out_ref_valid         (out_ref_valid),
    .out_ref_pid           (out_ref_pid),
    .out_is_reference      (out_is_reference),
    .out_stream_reset      (out_stream_reset),
    .out_seek_detected     (out_seek_detected),
    .out_pcr_jump          (out_pcr_jump)
  );

  // The queue never takes a beat while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push)
    else $error("queue pushed while full");

  // A popped item must come from a non-empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // A reference packet implies a usable PCR and a chosen reference.
  a_ref_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_reference) |-> (out_pcr_seen && out_ref_valid))
    else $error("reference result without PCR or reference");

  // A seek is reported only for reference packets; an idle gap may still
  // raise a reset beside it.
  a_seek_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_seek_detected) |-> out_is_reference)
    else $error("inconsistent seek classification");

  // The jump is zero unless a seek is reported.
  a_jump_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_seek_detected) |-> (out_pcr_jump == 27'sd0))
    else $error("nonzero jump without seek");

endmodule

### rtl/tsprt_front.sv
// ----------------------------------------------------------------------------
// tsprt_front
// Accepts packet headers, decodes PID and flags and pushes one classified
// item into the queue.
// ----------------------------------------------------------------------------
module tsprt_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_hdr_byte1,
  input  logic [7:0]           in_hdr_byte2,
  input  logic [7:0]           in_hdr_byte3,
  input  logic [7:0]           in_adapt_length,
  input  logic [7:0]           in_adapt_flags,
  input  logic [31:0]          in_pcr_top,
  input  logic [31:0]          in_now_ms,
  input  tsprt_pkg::q_stat_t   q_stat,
  output logic                 q_push,
  output tsprt_pkg::item_t     q_item
);
  import tsprt_pkg::*;

  logic        err;
  logic [12:0] pid;

  assign err      = in_hdr_byte1[B1_ERR];
  assign pid      = {in_hdr_byte1[4:0], in_hdr_byte2};
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_item.pid  = pid;
    q_item.pcr  = in_pcr_top;
    q_item.now  = in_now_ms;
    q_item.seen = in_hdr_byte3[B3_ADAPT] && (in_adapt_length >= PCR_MIN_ALEN) &&
                  in_adapt_flags[AF_PCR] && !err;
    q_item.tt   = (pid == TT_PID) && in_hdr_byte1[B1_PUSI] &&
                  in_hdr_byte3[B3_PAYLOAD] && !err;
  end

endmodule

### rtl/tsprt_queue.sv
// ----------------------------------------------------------------------------
// tsprt_queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module tsprt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tsprt_pkg::item_t    push_item,
  input  logic                pop,
  output logic                pop_valid,
  output tsprt_pkg::item_t    pop_item,
  output tsprt_pkg::q_stat_t  stat
);
  import tsprt_pkg::*;

  item_t             mem_r [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_r;
  logic [QPtrW-1:0]  rd_ptr_r;
  logic [QCntW-1:0]  count_r;
  logic              do_pop;

  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCntW'(QueueDepth));
  assign stat.empty = (count_r == '0);
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + QCntW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - QCntW'(1);
      end
    end
  end

endmodule

### rtl/tsprt_back.sv
// ----------------------------------------------------------------------------
// tsprt_back
// Sequencer that runs the candidate table, reference choice and PCR jump
// classification for one item at a time and holds the result register.
// ----------------------------------------------------------------------------
module tsprt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tsprt_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  tsprt_pkg::item_t    q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_pcr_seen,
  output logic                out_time_table_packet,
  output logic                out_ref_valid,
  output logic [12:0]         out_ref_pid,
  output logic                out_is_reference,
  output logic                out_stream_reset,
  output logic                out_seek_detected,
  output logic signed [26:0]  out_pcr_jump
);
  import tsprt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_TABLE, ST_DIFF, ST_DONE} state_t;

  state_t               state_r;
  item_t                item_r;
  logic                 hit_r;
  logic [CandIdxW-1:0]  hit_idx_r;
  logic                 pre_ref_r;
  logic                 is_ref_r;
  logic                 gap_r;
  logic [33:0]          diff_r;

  logic [12:0]          cand_pid_r  [CandSlots];
  logic [2:0]           cand_hits_r [CandSlots];
  logic [CandCntW-1:0]  cand_used_r;
  logic                 ref_valid_r;
  logic [12:0]          ref_pid_r;
  logic [31:0]          last_pcr_r;
  logic [31:0]          last_time_r;

  logic                 out_valid_r;
  logic                 out_seen_r;
  logic                 out_tt_r;
  logic                 out_ref_valid_r;
  logic [12:0]          out_ref_pid_r;
  logic                 out_is_ref_r;
  logic                 out_reset_r;
  logic                 out_seek_r;
  logic [26:0]          out_jump_r;

  logic                 hit_any;
  logic [CandIdxW-1:0]  hit_idx;
  logic [2:0]           need;
  logic [2:0]           hits_nxt;
  logic                 note;
  logic                 upd_en;
  logic                 ins_en;
  logic                 promote;
  logic                 is_ref_nxt;
  logic                 gap_nxt;
  logic                 wrap;
  logic [33:0]          diff_nxt;
  logic                 normal;
  logic [33:0]          mag;
  logic                 seek;
  logic                 done_go;

  // Lowest matching slot among the filled entries; the loop runs downward
  // so that the last assignment wins for the lowest index.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = CandSlots - 1; k >= 0; k--) begin
      if ((CandCntW'(k) < cand_used_r) && (cand_pid_r[k] == q_item.pid)) begin
        hit_any = 1'b1;
        hit_idx = CandIdxW'(k);
      end
    end
  end

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    need     = (cfg.promote_count == 3'd0) ? 3'd1 : cfg.promote_count;
    hits_nxt = (cand_hits_r[hit_idx_r] == HITS_MAX) ? HITS_MAX :
               cand_hits_r[hit_idx_r] + 3'd1;
    note     = (state_r == ST_TABLE) && item_r.seen && !pre_ref_r;
    upd_en   = note && hit_r;
    ins_en   = note && !hit_r && (cand_used_r < CandCntW'(CandSlots));
    promote  = (upd_en && (hits_nxt >= need)) || (ins_en && (need == 3'd1));
    // A promotion names this packet's PID, so the packet is then a reference.
    is_ref_nxt = item_r.seen && (pre_ref_r || promote);
    gap_nxt    = item_r.seen && ((item_r.now - last_time_r) >= {16'd0, cfg.idle_gap_ms});
  end

  always_comb begin
    wrap = (item_r.pcr < {12'd0, cfg.normal_window}) &&
           ((PCR_MAX - {12'd0, cfg.normal_window}) < last_pcr_r);
    diff_nxt = {2'b00, item_r.pcr} - {2'b00, last_pcr_r} + (wrap ? PCR_WRAP_ADD : 34'd0);
  end

  always_comb begin
    normal  = !diff_r[33] && (diff_r < {14'd0, cfg.normal_window});
    mag     = diff_r[33] ? (~diff_r + 34'd1) : diff_r;
    seek    = is_ref_r && !normal && (mag < {8'd0, cfg.seek_limit});
    done_go = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      cand_hits_r[hit_idx_r] <= hits_nxt;
    end
    if (ins_en) begin
      cand_pid_r[cand_used_r[CandIdxW-1:0]]  <= item_r.pid;
      cand_hits_r[cand_used_r[CandIdxW-1:0]] <= 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cand_used_r <= '0;
      ref_valid_r <= 1'b0;
      ref_pid_r   <= '0;
      last_pcr_r  <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loaded in the same cycle keeps the valid flag set.
      if (out_valid_r && out_ready && !done_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            item_r    <= q_item;
            hit_r     <= hit_any;
            hit_idx_r <= hit_idx;
            pre_ref_r <= ref_valid_r && (q_item.pid == ref_pid_r);
            state_r   <= ST_TABLE;
          end
        end
        ST_TABLE: begin
          if (promote) begin
            ref_valid_r <= 1'b1;
            ref_pid_r   <= item_r.pid;
          end
          if (is_ref_nxt) begin
            cand_used_r <= '0;
          end else if (ins_en) begin
            cand_used_r <= cand_used_r + CandCntW'(1);
          end
          if (item_r.seen) begin
            last_time_r <= item_r.now;
          end
          is_ref_r <= is_ref_nxt;
          gap_r    <= gap_nxt;
          state_r  <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_r  <= diff_nxt;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (done_go) begin
            out_valid_r     <= 1'b1;
            out_seen_r      <= item_r.seen;
            out_tt_r        <= item_r.tt;
            out_ref_valid_r <= ref_valid_r;
            out_ref_pid_r   <= ref_pid_r;
            out_is_ref_r    <= is_ref_r;
            out_seek_r      <= seek;
            out_reset_r     <= gap_r || (is_ref_r && !normal && !seek);
            out_jump_r      <= seek ? diff_r[26:0] : 27'd0;
            if (is_ref_r) begin
              last_pcr_r <= item_r.pcr;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pcr_seen          = out_seen_r;
  assign out_time_table_packet = out_tt_r;
  assign out_ref_valid         = out_ref_valid_r;
  assign out_ref_pid           = out_ref_pid_r;
  assign out_is_reference      = out_is_ref_r;
  assign out_stream_reset      = out_reset_r;
  assign out_seek_detected     = out_seek_r;
  assign out_pcr_jump          = signed'(out_jump_r);

endmodule

### tb/pcr_tracker_check.sv
// ----------------------------------------------------------------------------
// pcr_tracker_check
// Watches the packet, result and register channels of the PCR reference
// tracker, predicts the result of every accepted packet and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pcr_tracker_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_hdr_byte1,
  input  logic [7:0]                      in_hdr_byte2,
  input  logic [7:0]                      in_hdr_byte3,
  input  logic [7:0]                      in_adapt_length,
  input  logic [7:0]                      in_adapt_flags,
  input  logic [31:0]                     in_pcr_top,
  input  logic [31:0]                     in_now_ms,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_pcr_seen,
  input  logic                            out_time_table_packet,
  input  logic                            out_ref_valid,
  input  logic [12:0]                     out_ref_pid,
  input  logic                            out_is_reference,
  input  logic                            out_stream_reset,
  input  logic                            out_seek_detected,
  input  logic signed [26:0]              out_pcr_jump,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tsprt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tsprt_pkg::CfgDataW-1:0]  cfg_data,
  output int                              mismatches,
  output int                              awaited
);

  import tsprt_pkg::*;

  typedef struct packed {
    logic               pcr_seen;
    logic               tt_packet;
    logic               ref_valid;
    logic [12:0]        ref_pid;
    logic               is_ref;
    logic               stream_reset;
    logic               seek;
    logic signed [26:0] jump;
  } track_result_t;

  logic [15:0] idle_gap;
  logic [19:0] normal_window;
  logic [25:0] seek_limit;
  logic [2:0]  promote_count;

  logic [12:0] ref_pid_q;
  logic        ref_ok;
  logic [12:0] cand_pid [CandSlots];
  logic [2:0]  cand_hits [CandSlots];
  int          cand_count;
  logic [31:0] last_pcr;
  logic [31:0] last_seen_ms;

  track_result_t predicted_track [$];
  track_result_t want;
  int            errors = 0;

  assign mismatches = errors;

  // A PID seen often enough becomes the reference; a full table ignores
  // newcomers.
  function automatic void enroll_candidate(logic [12:0] pid);
    logic [2:0] need;
    bit         found;
    need  = (promote_count == 3'd0) ? 3'd1 : promote_count;
    found = 1'b0;
    for (int k = 0; k < cand_count; k++) begin
      if (!found && cand_pid[k] == pid) begin
        found = 1'b1;
        if (cand_hits[k] < HITS_MAX) cand_hits[k]++;
        if (cand_hits[k] >= need) begin
          ref_pid_q = pid;
          ref_ok    = 1'b1;
        end
      end
    end
    if (!found && cand_count < CandSlots) begin
      cand_pid[cand_count]  = pid;
      cand_hits[cand_count] = 3'd1;
      cand_count++;
      if (need == 3'd1) begin
        ref_pid_q = pid;
        ref_ok    = 1'b1;
      end
    end
  endfunction

  function automatic track_result_t track_packet(
    logic [7:0] b1, logic [7:0] b2, logic [7:0] b3, logic [7:0] alen,
    logic [7:0] aflags, logic [31:0] pcr, logic [31:0] now);
    track_result_t r;
    logic [12:0]   pid;
    logic          err;
    logic [31:0]   idle_span;
    longint        diff;
    longint        mag;
    r   = '0;
    pid = {b1[4:0], b2};
    err = b1[B1_ERR];
    r.pcr_seen  = b3[B3_ADAPT] && alen >= PCR_MIN_ALEN && aflags[AF_PCR] && !err;
    r.tt_packet = pid == TT_PID && b1[B1_PUSI] && b3[B3_PAYLOAD] && !err;
    if (r.pcr_seen) begin
      if (!(ref_ok && pid == ref_pid_q)) enroll_candidate(pid);
      if (ref_ok && pid == ref_pid_q) begin
        cand_count = 0;
        r.is_ref   = 1'b1;
      end
      idle_span      = now - last_seen_ms;
      r.stream_reset = idle_span >= {16'd0, idle_gap};
      last_seen_ms   = now;
      if (r.is_ref) begin
        diff = longint'({32'd0, pcr}) - longint'({32'd0, last_pcr});
        // Near the top of the 32-bit range a small new value is a wrap.
        if (pcr < {12'd0, normal_window} &&
            (PCR_MAX - {12'd0, normal_window}) < last_pcr)
          diff += 64'sh1_0000_0000;
        mag = (diff < 0) ? -diff : diff;
        if (!(diff >= 0 && diff < longint'({44'd0, normal_window}))) begin
          if (mag < longint'({38'd0, seek_limit})) begin
            r.seek = 1'b1;
            r.jump = diff[26:0];
          end else begin
            r.stream_reset = 1'b1;
          end
        end
        last_pcr = pcr;
      end
    end
    r.ref_valid = ref_ok;
    r.ref_pid   = ref_pid_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want_v,
                                      logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: out_%s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_gap      = IDLE_GAP_RST;
      normal_window = NORMAL_WINDOW_RST;
      seek_limit    = SEEK_LIMIT_RST;
      promote_count = PROMOTE_COUNT_RST;
      ref_pid_q     = '0;
      ref_ok        = 1'b0;
      cand_count    = 0;
      last_pcr      = '0;
      last_seen_ms  = '0;
      predicted_track.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_track.size() == 0) begin
          errors++;
          $display("%0t: result beat arrived with no packet awaiting it", $time);
        end else begin
          want = predicted_track.pop_front();
          check_field("pcr_seen", 32'(want.pcr_seen), 32'(out_pcr_seen));
          check_field("time_table_packet", 32'(want.tt_packet),
                      32'(out_time_table_packet));
          check_field("ref_valid", 32'(want.ref_valid), 32'(out_ref_valid));
          check_field("ref_pid", 32'(want.ref_pid), 32'(out_ref_pid));
          check_field("is_reference", 32'(want.is_ref), 32'(out_is_reference));
          check_field("stream_reset", 32'(want.stream_reset), 32'(out_stream_reset));
          check_field("seek_detected", 32'(want.seek), 32'(out_seek_detected));
          check_field("pcr_jump", 32'(want.jump), 32'(out_pcr_jump));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IDLE_GAP:      idle_gap      = cfg_data[15:0];
          REG_NORMAL_WINDOW: normal_window = cfg_data[19:0];
          REG_SEEK_LIMIT:    seek_limit    = cfg_data[25:0];
          REG_PROMOTE_COUNT: promote_count = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_track.push_back(track_packet(in_hdr_byte1, in_hdr_byte2, in_hdr_byte3,
                                               in_adapt_length, in_adapt_flags,
                                               in_pcr_top, in_now_ms));
    end
    awaited <= predicted_track.size();
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the PCR reference tracker with directed header beats, then with
// phases of random packet streams built around a shared PCR time base, under
// several register settings and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;

  import tsprt_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = CfgIdxW'(4);

  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 180;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  alen;
    logic [7:0]  aflags;
    logic [31:0] pcr;
    logic [31:0] now;
  } ts_packet_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [7:0]          in_hdr_byte1    = '0;
  logic [7:0]          in_hdr_byte2    = '0;
  logic [7:0]          in_hdr_byte3    = '0;
  logic [7:0]          in_adapt_length = '0;
  logic [7:0]          in_adapt_flags  = '0;
  logic [31:0]         in_pcr_top      = '0;
  logic [31:0]         in_now_ms       = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic                out_pcr_seen;
  logic                out_time_table_packet;
  logic                out_ref_valid;
  logic [12:0]         out_ref_pid;
  logic                out_is_reference;
  logic                out_stream_reset;
  logic                out_seek_detected;
  logic signed [26:0]  out_pcr_jump;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index       = '0;
  logic [CfgDataW-1:0] cfg_data        = '0;
  int                  mismatches;
  int                  awaited;

  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  logic [15:0] gen_idle;
  logic [19:0] gen_nw;
  logic [25:0] gen_seek;
  logic [31:0] pcr_clock;
  logic [31:0] ms_clock;
  logic [12:0] pid_pool [3];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  ts_pcr_reference_tracker_core i_dut (.*);

  pcr_tracker_check u_check (.*);

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Ends the run when no channel has moved a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Upper bits beyond each register's width carry junk that must be dropped.
  task automatic apply_settings(input logic [15:0] idle, input logic [19:0] nw,
                                input logic [25:0] seek, input logic [2:0] prom);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_IDLE_GAP, {junk[15:0], idle});
    write_reg(REG_NORMAL_WINDOW, {junk[11:0], nw});
    write_reg(REG_SEEK_LIMIT, {junk[5:0], seek});
    write_reg(REG_PROMOTE_COUNT, {junk[28:0], prom});
    cfg_valid <= 1'b0;
    gen_idle = idle;
    gen_nw   = nw;
    gen_seek = seek;
  endtask

  task automatic send(input ts_packet_t p);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_hdr_byte1    <= p.b1;
    in_hdr_byte2    <= p.b2;
    in_hdr_byte3    <= p.b3;
    in_adapt_length <= p.alen;
    in_adapt_flags  <= p.aflags;
    in_pcr_top      <= p.pcr;
    in_now_ms       <= p.now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  function automatic ts_packet_t pcr_pkt(logic [12:0] pid, logic [31:0] pcr,
                                         logic [31:0] now);
    ts_packet_t p;
    p.b1     = {3'b000, pid[12:8]};
    p.b2     = pid[7:0];
    p.b3     = 8'h30;
    p.alen   = 8'd7;
    p.aflags = 8'h10;
    p.pcr    = pcr;
    p.now    = now;
    return p;
  endfunction

  // Mostly PCR beats of a few PIDs on one advancing time base, with seeks,
  // large jumps, wraps and idle gaps mixed in; the rest is plain payload,
  // time-table packets and raw noise.
  function automatic ts_packet_t next_packet();
    ts_packet_t   p;
    logic [127:0] wide;
    logic [31:0]  junk;
    logic [31:0]  mag;
    logic [12:0]  pid;
    int           r;
    int           pick;
    wide = {$urandom(), $urandom(), $urandom(), $urandom()};
    p    = wide[103:0];
    junk = $urandom();
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    pid  = (pick < 5) ? pid_pool[0] : (pick < 8) ? pid_pool[1] : pid_pool[2];
    if (r < 60) begin
      case ($urandom_range(0, 19))
        0: ms_clock += gen_idle + $urandom_range(0, 5000);
        1: ms_clock += gen_idle;
        2: ms_clock += gen_idle - 1;
        3: ms_clock = $urandom();
        default: ms_clock += $urandom_range(0, gen_idle / 2);
      endcase
      case ($urandom_range(0, 24))
        0: begin
          mag = (gen_seek > gen_nw) ? $urandom_range(gen_nw, gen_seek - 1)
                                    : $urandom_range(0, gen_seek);
          if ($urandom_range(0, 1) != 0) pcr_clock += mag;
          else pcr_clock -= mag;
        end
        1: pcr_clock -= $urandom_range(1, gen_nw);
        2: pcr_clock = $urandom();
        3: pcr_clock = PCR_MAX - $urandom_range(0, gen_nw);
        4: pcr_clock += gen_nw;
        default: pcr_clock += $urandom_range(0, gen_nw - 1);
      endcase
      p.b1     = {($urandom_range(0, 15) == 0), junk[1:0], pid[12:8]};
      p.b2     = pid[7:0];
      p.b3     = {junk[3:2], 1'b1, junk[8:4]};
      p.alen   = 8'($urandom_range(5, 255));
      p.aflags = junk[16:9] | 8'h10;
      p.pcr    = pcr_clock;
      p.now    = ms_clock;
    end else if (r < 78) begin
      {p.b1[4:0], p.b2} = pid;
      case ($urandom_range(0, 3))
        0: p.b1[B1_ERR] = 1'b1;
        1: p.b3[B3_ADAPT] = 1'b0;
        2: p.alen = 8'($urandom_range(0, 4));
        default: p.aflags[AF_PCR] = 1'b0;
      endcase
      p.now = ms_clock;
    end else if (r < 86) begin
      {p.b1[4:0], p.b2}  = TT_PID;
      p.b1[B1_PUSI]      = ($urandom_range(0, 3) != 0);
      p.b1[B1_ERR]       = ($urandom_range(0, 3) == 0);
      p.b3[B3_PAYLOAD]   = ($urandom_range(0, 3) != 0);
      p.now              = ms_clock;
    end
    return p;
  endfunction

  initial begin
    ts_packet_t p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults except a quick promotion; an unmapped index must do nothing.
    write_reg(REG_PROMOTE_COUNT, 32'd2);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;

    p = '0;
    send(p);
    p = '1;
    send(p);
    p = pcr_pkt(13'h0100, 32'd50, 32'd1);
    p.alen = 8'd4;
    send(p);
    p = pcr_pkt(13'h0100, 32'd50, 32'd2);
    p.b3 = 8'h10;
    send(p);
    p = pcr_pkt(13'h0100, 32'd50, 32'd3);
    p.aflags = 8'hEF;
    send(p);
    p = '0;
    {p.b1[4:0], p.b2} = TT_PID;
    p.b1[B1_PUSI]     = 1'b1;
    p.b3[B3_PAYLOAD]  = 1'b1;
    send(p);
    // Nine distinct PCR PIDs: the last one finds the candidate table full.
    for (int n = 0; n < 9; n++)
      send(pcr_pkt(13'((n == 8) ? 32'h1FFF : 32'h0100 + n), 32'd1000 * n, 32'd10 + n));
    send(pcr_pkt(13'h0100, 32'd1000, 32'd100));
    send(pcr_pkt(13'h0100, 32'd20000, 32'd110));
    send(pcr_pkt(13'h0100, 32'd1020000, 32'd120));
    send(pcr_pkt(13'h0100, 32'd500000, 32'd130));
    send(pcr_pkt(13'h0100, 32'hF000_0000, 32'd140));
    send(pcr_pkt(13'h0100, PCR_MAX, 32'd150));
    send(pcr_pkt(13'h0100, 32'h0000_0100, 32'd160));
    send(pcr_pkt(13'h0100, 32'h0000_0200, 32'd5200));
    drain();

    // All registers at zero: first sighting promotes, every PCR resets.
    apply_settings(16'd0, 20'd0, 26'd0, 3'd0);
    send(pcr_pkt(13'h0021, 32'd5, 32'd6000));
    send(pcr_pkt(13'h0021, 32'd5, 32'd6000));
    drain();

    pcr_clock = $urandom();
    ms_clock  = $urandom();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: apply_settings(IDLE_GAP_RST, NORMAL_WINDOW_RST, SEEK_LIMIT_RST, PROMOTE_COUNT_RST);
        1: apply_settings(16'hFFFF, 20'hF_FFFF, 26'h3FF_FFFF, 3'd7);
        2: apply_settings(16'd1, 20'd1, 26'd1, 3'd1);
        3: apply_settings(16'd500, 20'd9000, 26'd2000000, 3'd3);
        4: apply_settings(16'd3000, 20'd45000, 26'h3FF_FFFF, 3'd2);
        5: apply_settings(16'hFFFF, 20'd1, 26'd1000000, 3'd4);
        6: apply_settings(16'd150, 20'hF_FFFF, 26'd1048576, 3'd6);
        default: apply_settings(16'd2000, 20'd45000, 26'd40500000, 3'd2);
      endcase
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 36; stall_pct = 36; end
      endcase
      for (int k = 0; k < 3; k++) pid_pool[k] = 13'($urandom_range(0, 8191));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the sender off until the pipeline has fully emptied.
        if (n == PHASE_ITEMS / 2 && ph % 2 == 1) drain();
        send(next_packet());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### ts_pcr_reference_tracker_core.f
rtl/tsprt_pkg.sv
rtl/tsprt_front.sv
rtl/tsprt_queue.sv
rtl/tsprt_back.sv
rtl/ts_pcr_reference_tracker_core.sv
tb/pcr_tracker_check.sv
tb/tb.sv
